// ===== design/kalman_angle_fusion_core_macros.svh =====
// Assertion macros shared by the kalman angle fusion core modules.
`ifndef KALMAN_ANGLE_FUSION_CORE_MACROS_SVH
`define KALMAN_ANGLE_FUSION_CORE_MACROS_SVH

// same-cycle implication
`define KAF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KAF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kaf_pkg.sv =====
// Types, constants and microcode table of the kalman angle fusion core.
package kaf_pkg;

  localparam int RATE_W  = 12;
  localparam int MEAS_W  = 9;
  localparam int ANGLE_W = 32;
  localparam int VAR_W   = 32;
  localparam int DT_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd2;

  localparam logic [DT_W-1:0]  RATE_STEP_RST     = 16'd459;
  localparam logic [VAR_W-1:0] PROCESS_NOISE_RST = 32'h0064_0004;
  localparam logic [VAR_W-1:0] MEASURE_NOISE_RST = 32'h0009_0000;

  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_FIRST = 5'd16;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_MUL_RATE = 4'd1;
  localparam logic [PC_W-1:0] PC_DIV  = 4'd4;
  localparam logic [PC_W-1:0] PC_WB   = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_RATE,
    OP_PRED,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN,
    OP_DIFF,
    OP_MUL_DIFF,
    OP_CORR,
    OP_MUL_VAR,
    OP_WB
  } kaf_op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_WAIT_OUT,
    C_DIV_LOOP,
    C_ALWAYS
  } kaf_cond_t;

  typedef struct packed {
    kaf_op_t           op;
    kaf_cond_t         cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    kaf_op_t op;
    logic    fire;
  } kaf_ctl_t;

  typedef struct packed {
    logic div_more;
    logic out_busy;
  } kaf_stat_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{OP_LOAD,     C_WAIT_IN,  PC_IDLE};
      4'd1:    w = '{OP_MUL_RATE, C_NEXT,     PC_IDLE};
      4'd2:    w = '{OP_PRED,     C_NEXT,     PC_IDLE};
      4'd3:    w = '{OP_DIV_INIT, C_NEXT,     PC_IDLE};
      4'd4:    w = '{OP_DIV_STEP, C_DIV_LOOP, PC_DIV};
      4'd5:    w = '{OP_GAIN,     C_NEXT,     PC_IDLE};
      4'd6:    w = '{OP_DIFF,     C_NEXT,     PC_IDLE};
      4'd7:    w = '{OP_MUL_DIFF, C_NEXT,     PC_IDLE};
      4'd8:    w = '{OP_CORR,     C_NEXT,     PC_IDLE};
      4'd9:    w = '{OP_MUL_VAR,  C_NEXT,     PC_IDLE};
      4'd10:   w = '{OP_WB,       C_WAIT_OUT, PC_WB};
      default: w = '{OP_NOP,      C_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [34:0] v);
    logic signed [ANGLE_W-1:0] r;
    if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== design/kaf_sample_if.sv =====
// Input sample channel: axis, gyro rate and accelerometer angle.
interface kaf_sample_if;
  logic                                valid;
  logic                                ready;
  logic                                axis;
  logic signed [kaf_pkg::RATE_W-1:0]   gyro_rate;
  logic signed [kaf_pkg::MEAS_W-1:0]   accel_angle;

  modport source (output valid, axis, gyro_rate, accel_angle, input ready);
  modport sink   (input valid, axis, gyro_rate, accel_angle, output ready);
endinterface

// ===== design/kaf_result_if.sv =====
// Result channel: axis, fused angle and variance.
interface kaf_result_if;
  logic                                valid;
  logic                                ready;
  logic                                axis_out;
  logic signed [kaf_pkg::ANGLE_W-1:0]  fused_angle;
  logic [kaf_pkg::VAR_W-1:0]           variance_out;

  modport source (output valid, axis_out, fused_angle, variance_out, input ready);
  modport sink   (input valid, axis_out, fused_angle, variance_out, output ready);
endinterface

// ===== design/kaf_cfg_if.sv =====
// Configuration write channel: register index and data.
interface kaf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [kaf_pkg::CFG_IDX_W-1:0]      index;
  logic [kaf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/kaf_seq.sv =====
// Microcode sequencer: step counter, control ROM fetch and jump logic.
`include "kalman_angle_fusion_core_macros.svh"

module kaf_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  kaf_pkg::kaf_stat_t stat,
  output kaf_pkg::kaf_ctl_t  ctl
);

  logic [kaf_pkg::PC_W-1:0] pc;
  logic [kaf_pkg::PC_W-1:0] pc_next;
  kaf_pkg::ucode_t          uw;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= kaf_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    uw     = kaf_pkg::ucode_rom(pc);
    ctl.op = uw.op;
    unique case (uw.cond)
      kaf_pkg::C_NEXT: begin
        ctl.fire = 1'b1;
        pc_next  = pc + kaf_pkg::PC_W'(1);
      end
      kaf_pkg::C_WAIT_IN: begin
        ctl.fire = in_valid;
        pc_next  = in_valid ? pc + kaf_pkg::PC_W'(1) : uw.target;
      end
      kaf_pkg::C_WAIT_OUT: begin
        ctl.fire = !stat.out_busy;
        pc_next  = stat.out_busy ? uw.target : pc + kaf_pkg::PC_W'(1);
      end
      kaf_pkg::C_DIV_LOOP: begin
        ctl.fire = 1'b1;
        pc_next  = stat.div_more ? uw.target : pc + kaf_pkg::PC_W'(1);
      end
      kaf_pkg::C_ALWAYS: begin
        ctl.fire = 1'b1;
        pc_next  = uw.target;
      end
      default: begin
        ctl.fire = 1'b0;
        pc_next  = kaf_pkg::PC_IDLE;
      end
    endcase
  end

  `KAF_ASSERT_NEXT(a_load_advances, clk, rst, ctl.op == kaf_pkg::OP_LOAD && ctl.fire, pc == kaf_pkg::PC_MUL_RATE, "accepted word did not start the program")

endmodule

// ===== design/kaf_datapath.sv =====
// Datapath: per-axis state, config registers, shared multiplier, divider, output register.
`include "kalman_angle_fusion_core_macros.svh"

module kaf_datapath #(
  parameter int AXES = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  kaf_pkg::kaf_ctl_t  ctl,
  output kaf_pkg::kaf_stat_t stat,
  kaf_sample_if.sink         sample,
  kaf_result_if.source       result,
  kaf_cfg_if.sink            cfg
);

  localparam int CH_W = (AXES > 1) ? $clog2(AXES) : 1;

  logic signed [kaf_pkg::ANGLE_W-1:0] angle_store [AXES];
  logic [kaf_pkg::VAR_W-1:0]          variance_store [AXES];

  logic [kaf_pkg::DT_W-1:0]  rate_step;
  logic [kaf_pkg::VAR_W-1:0] process_noise;
  logic [kaf_pkg::VAR_W-1:0] measure_noise;

  logic                               axis;
  logic [CH_W-1:0]                    ch;
  logic [CH_W-1:0]                    ch_in;
  logic signed [kaf_pkg::RATE_W-1:0]  rate;
  logic signed [kaf_pkg::MEAS_W-1:0]  meas;
  logic signed [kaf_pkg::ANGLE_W-1:0] ang;
  logic [kaf_pkg::VAR_W-1:0]          var_q;
  logic [32:0]                        den;
  logic [33:0]                        rem;
  logic [16:0]                        quo;
  logic [kaf_pkg::DIV_CNT_W-1:0]      cnt;
  logic [kaf_pkg::GAIN_W-1:0]         gain;
  logic signed [33:0]                 diff;
  logic signed [52:0]                 prod;

  logic                               out_valid;
  logic                               out_axis;
  logic signed [kaf_pkg::ANGLE_W-1:0] out_angle;
  logic [kaf_pkg::VAR_W-1:0]          out_var;

  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] mul_p;
  logic signed [34:0] pred_sum;
  logic signed [34:0] corr_sum;
  logic [32:0]        var_sum;
  logic               div_ge;
  logic [33:0]        div_sub;
  logic [33:0]        div_keep;
  logic [kaf_pkg::VAR_W-1:0] var_new;

  assign ch_in = (AXES > 1) ? CH_W'(sample.axis) : '0;

  // shared multiplier, operands picked by the current step
  always_comb begin
    unique case (ctl.op)
      kaf_pkg::OP_MUL_RATE: begin
        mul_a = 35'(rate);
        mul_b = {2'b00, rate_step};
      end
      kaf_pkg::OP_MUL_DIFF: begin
        mul_a = {diff[33], diff};
        mul_b = {2'b00, gain};
      end
      kaf_pkg::OP_MUL_VAR: begin
        mul_a = {3'b000, var_q};
        mul_b = {1'b0, 17'(17'h1_0000 - {1'b0, gain})};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign pred_sum = 35'(ang) + 35'($signed(prod[27:0]));
  assign corr_sum = 35'(ang) + $signed(prod[50:16]);
  assign var_sum  = {1'b0, var_q} + {1'b0, process_noise};
  assign div_ge   = rem >= {1'b0, den};
  assign div_sub  = rem - {1'b0, den};
  assign div_keep = div_ge ? div_sub : rem;
  assign var_new  = prod[47:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step     <= kaf_pkg::RATE_STEP_RST;
      process_noise <= kaf_pkg::PROCESS_NOISE_RST;
      measure_noise <= kaf_pkg::MEASURE_NOISE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        kaf_pkg::CFG_RATE_STEP:     rate_step     <= cfg.data[kaf_pkg::DT_W-1:0];
        kaf_pkg::CFG_PROCESS_NOISE: process_noise <= cfg.data;
        kaf_pkg::CFG_MEASURE_NOISE: measure_noise <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        angle_store[i]    <= '0;
        variance_store[i] <= '0;
      end
    end else if (ctl.fire && ctl.op == kaf_pkg::OP_WB) begin
      angle_store[ch]    <= ang;
      variance_store[ch] <= var_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fire && ctl.op == kaf_pkg::OP_WB) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      unique case (ctl.op)
        kaf_pkg::OP_LOAD: begin
          axis  <= sample.axis;
          ch    <= ch_in;
          rate  <= sample.gyro_rate;
          meas  <= sample.accel_angle;
          ang   <= angle_store[ch_in];
          var_q <= variance_store[ch_in];
        end
        kaf_pkg::OP_MUL_RATE, kaf_pkg::OP_MUL_DIFF, kaf_pkg::OP_MUL_VAR: begin
          prod <= mul_p;
        end
        kaf_pkg::OP_PRED: begin
          ang   <= kaf_pkg::sat_angle(pred_sum);
          var_q <= var_sum[32] ? '1 : var_sum[31:0];
        end
        kaf_pkg::OP_DIV_INIT: begin
          den <= {1'b0, var_q} + {1'b0, measure_noise};
          rem <= {2'b00, var_q};
          quo <= '0;
          cnt <= kaf_pkg::DIV_FIRST;
        end
        kaf_pkg::OP_DIV_STEP: begin
          rem <= {div_keep[32:0], 1'b0};
          quo <= {quo[15:0], div_ge};
          cnt <= cnt - kaf_pkg::DIV_CNT_W'(1);
        end
        kaf_pkg::OP_GAIN: begin
          if (den == '0) begin
            gain <= '0;
          end else if (quo[16]) begin
            gain <= '1;
          end else begin
            gain <= quo[15:0];
          end
        end
        kaf_pkg::OP_DIFF: begin
          diff <= $signed({{9{meas[8]}}, meas, 16'h0000}) - 34'(ang);
        end
        kaf_pkg::OP_CORR: begin
          ang <= kaf_pkg::sat_angle(corr_sum);
        end
        kaf_pkg::OP_WB: begin
          out_axis  <= axis;
          out_angle <= ang;
          out_var   <= var_new;
        end
        default: ;
      endcase
    end
  end

  assign stat.div_more = (cnt != '0);
  assign stat.out_busy = out_valid && !result.ready;

  assign sample.ready        = (ctl.op == kaf_pkg::OP_LOAD);
  assign cfg.ready           = 1'b1;
  assign result.valid        = out_valid;
  assign result.axis_out     = out_axis;
  assign result.fused_angle  = out_angle;
  assign result.variance_out = out_var;

  `KAF_ASSERT_NEXT(a_wb_sets_valid, clk, rst, ctl.fire && ctl.op == kaf_pkg::OP_WB, result.valid, "write-back did not raise the result word")
  `KAF_ASSERT_IMPL(a_div_rem_bound, clk, rst, ctl.op == kaf_pkg::OP_DIV_STEP, (rem < {den, 1'b0}) || (den == '0), "divider remainder out of range")
  `KAF_ASSERT_IMPL(a_var_shrinks, clk, rst, ctl.op == kaf_pkg::OP_WB, var_new <= var_q, "corrected variance above predicted variance")

endmodule

// ===== design/kalman_angle_fusion_core.sv =====
// Top level of the two-axis scalar Kalman angle fusion core.
//
//   port     dir  word                                          handshake
//   sample   in   axis, gyro_rate, accel_angle                  valid/ready
//   result   out  axis_out, fused_angle, variance_out           valid/ready
//   cfg      in   index, data (rate_step, process/measure noise) valid/ready
//
// Sample words are handled one at a time; the 17-step restoring divider for
// the gain takes most of the program, the rest is one step per multiply and
// update in the microcode. A result word is registered in the write-back step.
// The next sample word is taken while the previous result still waits;
// a stalled result holds the write-back step until the output register frees.
// Reset clears both axis states and loads the default config; cfg.ready is always high.
module kalman_angle_fusion_core #(
  parameter int AXES = 2
) (
  input logic          clk,
  input logic          rst,
  kaf_sample_if.sink   sample,
  kaf_result_if.source result,
  kaf_cfg_if.sink      cfg
);

  kaf_pkg::kaf_ctl_t  ctl;
  kaf_pkg::kaf_stat_t stat;

  kaf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  kaf_datapath #(
    .AXES (AXES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .stat   (stat),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the Kalman angle fusion core: predicts every fused word and compares.
module testbench;

  localparam int N_AXES = 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SAMPLE_TARGET = 1050;

  typedef struct packed {
    logic                               axis;
    logic signed [kaf_pkg::ANGLE_W-1:0] angle;
    logic [kaf_pkg::VAR_W-1:0]          variance;
  } fused_word_t;

  class fusion_scoreboard;
    logic signed [kaf_pkg::ANGLE_W-1:0] angle_est [N_AXES];
    logic [kaf_pkg::VAR_W-1:0]          var_est [N_AXES];
    logic [kaf_pkg::DT_W-1:0]           dt;
    logic [kaf_pkg::VAR_W-1:0]          q_noise;
    logic [kaf_pkg::VAR_W-1:0]          r_noise;
    fused_word_t                        pending[$];
    int errors, words_seen, cfg_writes, sat_hits, gain_clamps, zero_den;

    function new();
      for (int i = 0; i < N_AXES; i++) begin
        angle_est[i] = '0;
        var_est[i] = '0;
      end
      dt = kaf_pkg::RATE_STEP_RST;
      q_noise = kaf_pkg::PROCESS_NOISE_RST;
      r_noise = kaf_pkg::MEASURE_NOISE_RST;
    endfunction

    function void set_reg(logic [kaf_pkg::CFG_IDX_W-1:0] idx,
                          logic [kaf_pkg::CFG_DATA_W-1:0] data);
      cfg_writes++;
      case (idx)
        kaf_pkg::CFG_RATE_STEP:     dt = data[kaf_pkg::DT_W-1:0];
        kaf_pkg::CFG_PROCESS_NOISE: q_noise = data;
        kaf_pkg::CFG_MEASURE_NOISE: r_noise = data;
        default: ;
      endcase
    endfunction

    function longint clamp_angle(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void note_sample(logic ax, logic signed [kaf_pkg::RATE_W-1:0] rate,
                              logic signed [kaf_pkg::MEAS_W-1:0] meas);
      longint ang, diff, corr;
      longint unsigned v, den, g;
      int ch;
      fused_word_t w;
      ch = (int'(ax) < N_AXES) ? int'(ax) : N_AXES - 1;
      // predict
      ang = longint'(angle_est[ch]) + longint'(rate) * longint'(dt);
      if (ang != clamp_angle(ang)) sat_hits++;
      ang = clamp_angle(ang);
      v = 64'(var_est[ch]) + 64'(q_noise);
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      // gain
      den = v + 64'(r_noise);
      if (den == 0) begin
        g = 0;
        zero_den++;
      end else begin
        g = (v << 16) / den;
        if (g > 64'hFFFF) begin
          g = 64'hFFFF;
          gain_clamps++;
        end
      end
      // correct; >>> on a signed value floors
      diff = longint'(meas) * 65536 - ang;
      corr = longint'(g) * diff;
      ang = clamp_angle(ang + (corr >>> 16));
      v = (v * (64'd65536 - g)) >> 16;
      angle_est[ch] = ang[kaf_pkg::ANGLE_W-1:0];
      var_est[ch] = v[kaf_pkg::VAR_W-1:0];
      w.axis = ax;
      w.angle = angle_est[ch];
      w.variance = var_est[ch];
      pending.push_back(w);
    endfunction

    function void check_word(logic ax, logic signed [kaf_pkg::ANGLE_W-1:0] ang,
                             logic [kaf_pkg::VAR_W-1:0] v);
      fused_word_t w;
      words_seen++;
      if (pending.size() == 0) begin
        errors++;
        $error("unexpected result word: axis_out %0d fused_angle %0d variance_out %0d",
               ax, ang, v);
        return;
      end
      w = pending.pop_front();
      if (ax !== w.axis) begin
        errors++;
        $error("axis_out expected %0d actual %0d", w.axis, ax);
      end
      if (ang !== w.angle) begin
        errors++;
        $error("fused_angle expected %0d actual %0d", w.angle, ang);
      end
      if (v !== w.variance) begin
        errors++;
        $error("variance_out expected %0d actual %0d", w.variance, v);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycle_count = 0;
  int samples_sent = 0;
  logic src_gaps = 1'b0;
  logic snk_stalls = 1'b0;
  fusion_scoreboard sb;

  kaf_sample_if sample_ch();
  kaf_result_if result_ch();
  kaf_cfg_if    cfg_ch();

  kalman_angle_fusion_core #(.AXES(N_AXES)) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_reg(cfg_ch.index, cfg_ch.data);
      if (sample_ch.valid && sample_ch.ready)
        sb.note_sample(sample_ch.axis, sample_ch.gyro_rate, sample_ch.accel_angle);
      if (result_ch.valid && result_ch.ready)
        sb.check_word(result_ch.axis_out, result_ch.fused_angle, result_ch.variance_out);
    end
  end

  task automatic write_reg(input logic [kaf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kaf_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_filter(input logic [kaf_pkg::DT_W-1:0] step,
                                input logic [kaf_pkg::VAR_W-1:0] q,
                                input logic [kaf_pkg::VAR_W-1:0] r);
    // junk in the upper half of the rate_step word must be dropped
    write_reg(kaf_pkg::CFG_RATE_STEP, {16'($urandom()), step});
    write_reg(kaf_pkg::CFG_PROCESS_NOISE, q);
    write_reg(kaf_pkg::CFG_MEASURE_NOISE, r);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(input logic ax, input logic signed [kaf_pkg::RATE_W-1:0] rate,
                             input logic signed [kaf_pkg::MEAS_W-1:0] meas);
    int gap;
    gap = src_gaps ? int'($urandom_range(19, 0)) : 0;
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.axis        <= ax;
    sample_ch.gyro_rate   <= rate;
    sample_ch.accel_angle <= meas;
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
  endtask

  task automatic wait_results_done();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_sample(input logic ax, input int rate_mode);
    int r, m;
    case (rate_mode)
      0:       r = int'($urandom_range(4095, 0));
      1:       r = int'($urandom_range(100, 0)) - 50;
      2:       r = int'($urandom_range(2047, 1800));
      default: r = -int'($urandom_range(2048, 1800));
    endcase
    if ($urandom_range(4, 0) == 0) m = int'($urandom_range(511, 0));
    else m = int'($urandom_range(360, 0)) - 180;
    send_sample(ax, r[kaf_pkg::RATE_W-1:0], m[kaf_pkg::MEAS_W-1:0]);
  endtask

  function automatic logic [kaf_pkg::VAR_W-1:0] pick_noise(
      input logic [kaf_pkg::VAR_W-1:0] dflt);
    case ($urandom_range(6, 0))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return dflt;
      3:       return 32'($urandom_range(32'h00FF_FFFF, 0));
      4:       return 32'($urandom_range(32'h000F_FFFF, 32'h0000_1000));
      5:       return 32'($urandom_range(32'h00A0_0000, 32'h0001_0000));
      default: return 32'($urandom());
    endcase
  endfunction

  initial begin
    int n, dirs;
    logic [kaf_pkg::DT_W-1:0] step;
    sample_ch.valid       <= 1'b0;
    sample_ch.axis        <= 1'b0;
    sample_ch.gyro_rate   <= '0;
    sample_ch.accel_angle <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero noise with zero variance: denominator is zero, gain 0
    program_filter(16'hFFFF, 32'd0, 32'd0);
    send_sample(1'b0, 12'sh000, 9'sh000);
    send_sample(1'b1, 12'sh7FF, 9'sh0FF);
    wait_results_done();
    // zero measurement noise: gain clamps at full scale
    program_filter(16'hFFFF, 32'h0001_0000, 32'd0);
    send_sample(1'b0, 12'sh800, 9'sh100);
    send_sample(1'b1, 12'shFFF, 9'sd180);
    send_sample(1'b0, 12'sh001, -9'sd180);
    wait_results_done();
    // variance saturation, dt of zero
    program_filter(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(1'b0, 12'sh7FF, 9'sh0FF);
    send_sample(1'b1, 12'sh800, 9'sh100);
    send_sample(1'b1, 12'sh7FF, -9'sd180);
    send_sample(1'b0, 12'sh000, 9'sh000);
    wait_results_done();
    program_filter(16'($urandom()), kaf_pkg::PROCESS_NOISE_RST, 32'd1);
    send_sample(1'b0, 12'sh555, 9'sh0AA);
    send_sample(1'b1, 12'shAAA, 9'sh155);
    send_sample(1'b0, 12'sd100, 9'sd45);
    wait_results_done();
    program_filter(kaf_pkg::RATE_STEP_RST, kaf_pkg::PROCESS_NOISE_RST,
                   kaf_pkg::MEASURE_NOISE_RST);
    send_sample(1'b1, -12'sd90, -9'sd30);
    send_sample(1'b0, 12'sd0, 9'sd0);

    while (samples_sent < SAMPLE_TARGET) begin
      wait_results_done();
      src_gaps = ($urandom_range(3, 0) != 0);
      if ($urandom_range(4, 0) == 0) begin
        // flush variance to near zero, then drift hard toward an angle bound
        program_filter(16'($urandom()), 32'd0, 32'd0);
        for (int i = 0; i < 4; i++) send_random_sample(i[0], 0);
        wait_results_done();
        program_filter(16'($urandom_range(65535, 60000)), 32'd0,
                       32'hFFFF_FFFF - 32'($urandom_range(65535, 0)));
        dirs = int'($urandom_range(3, 0));
        repeat (44) begin
          n = int'($urandom_range(1, 0));
          send_random_sample(n[0], dirs[n] ? 2 : 3);
        end
      end else begin
        case ($urandom_range(4, 0))
          0:       step = '0;
          1:       step = 16'hFFFF;
          2:       step = kaf_pkg::RATE_STEP_RST;
          default: step = 16'($urandom());
        endcase
        program_filter(step, pick_noise(kaf_pkg::PROCESS_NOISE_RST),
                       pick_noise(kaf_pkg::MEASURE_NOISE_RST));
        n = int'($urandom_range(120, 30));
        repeat (n) send_random_sample(1'($urandom()), int'($urandom_range(2, 0)) == 0 ? 1 : 0);
      end
    end

    wait_results_done();
    repeat (40) @(posedge clk);
    $display("%0d sample words in, %0d result words checked, %0d register writes",
             samples_sent, sb.words_seen, sb.cfg_writes);
    $display("angle clamps %0d, gain clamps %0d, zero-denominator steps %0d",
             sb.sat_hits, sb.gain_clamps, sb.zero_den);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int stall, taken, next_switch;
    taken = 0;
    next_switch = 20;
    result_ch.ready <= 1'b0;
    forever begin
      if (taken >= next_switch) begin
        snk_stalls = ($urandom_range(3, 0) != 0);
        next_switch = taken + int'($urandom_range(80, 20));
      end
      stall = snk_stalls ? int'($urandom_range(19, 0)) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      taken++;
    end
  end

endmodule

// ===== kalman_angle_fusion_core.f =====
+incdir+design
design/kaf_pkg.sv
design/kaf_sample_if.sv
design/kaf_result_if.sv
design/kaf_cfg_if.sv
design/kaf_seq.sv
design/kaf_datapath.sv
design/kalman_angle_fusion_core.sv
bench/testbench.sv
